// ===== design/ctb_pkg.sv =====
`default_nettype none
package ctb_pkg;

	localparam int NODE_W            = 6;
	localparam int IN_VALUE_W        = 32;
	localparam int DEF_MAX_LEN       = 64;
	localparam int DEF_VALUE_WIDTH   = 32;

	typedef struct packed {
		logic signed [IN_VALUE_W-1:0] value;
		logic                         last_item;
	} ctb_item_t;

	typedef struct packed {
		logic [NODE_W-1:0] node_index;
		logic [NODE_W-1:0] parent_index;
		logic              parent_valid;
		logic [NODE_W-1:0] left_index;
		logic              left_valid;
		logic [NODE_W-1:0] right_index;
		logic              right_valid;
		logic              overflow;
		logic              last_node;
	} ctb_result_t;

	// Status one stack cell reports for the value on the broadcast bus.
	typedef struct packed {
		logic keep;
		logic top;
		logic first_pop;
		logic push;
	} ctb_cell_stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LINK,
		S_EMIT
	} ctb_state_t;

endpackage
`default_nettype wire

// ===== design/ctb_link_ram.sv =====
`default_nettype none
module ctb_link_ram #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 6
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/ctb_cell.sv =====
`default_nettype none
module ctb_cell #(
	parameter int KEY_W = 32,
	parameter int IDX_W = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  insert,
	input  wire logic                  clear,
	input  wire logic [KEY_W-1:0]      new_key,
	input  wire logic [IDX_W-1:0]      new_node,
	input  wire logic                  below_keep,
	input  wire logic                  above_keep,
	output ctb_pkg::ctb_cell_stat_t    stat,
	output logic      [IDX_W-1:0]      node
);
	import ctb_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] node_q;
	logic             pop;

	// Keys never fall toward the top, so the popped cells form a suffix
	// and each boundary is found from the neighbors alone.
	assign pop            = valid_q && (key_q > new_key);
	assign stat.keep      = valid_q && !pop;
	assign stat.top       = stat.keep && !above_keep;
	assign stat.first_pop = pop && below_keep;
	assign stat.push      = !stat.keep && below_keep;
	assign node           = node_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (insert) begin
			valid_q <= stat.keep || stat.push;
		end
	end

	always_ff @(posedge clk) begin
		if (insert && stat.push) begin
			key_q  <= new_key;
			node_q <= new_node;
		end
	end

endmodule
`default_nettype wire

// ===== design/cartesian_tree_builder.sv =====
//  Channel   Direction  Handshake               Beat
//  item      in         start & !busy           value, last_item
//  result    out        result_valid (1 cycle)  node, parent, left, right links, flags
//
//  An item is taken in S_IDLE, where the stack row compares, pops and pushes;
//  its link writes follow in S_LINK, with busy high. An item past capacity is dropped.
//  A last item then runs S_EMIT, one read per node from the link memories, each read
//  registered in s1 and s2 before the result; busy drops after the final read is issued.
//  Reset clears the stack cells, the link valid bits, the count and the flag.
//  The receiver cannot stall: each result beat is shown for exactly one cycle.
`default_nettype none
module cartesian_tree_builder #(
	parameter int MAX_LEN     = ctb_pkg::DEF_MAX_LEN,
	parameter int VALUE_WIDTH = ctb_pkg::DEF_VALUE_WIDTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire ctb_pkg::ctb_item_t  item,
	output logic                     result_valid,
	output ctb_pkg::ctb_result_t     result
);
	import ctb_pkg::*;

	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam logic [VALUE_WIDTH-1:0] SIGN_MASK = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);

	ctb_state_t state_q, state_d;

	logic             accept, full, insert, issue, issue_end;
	logic [CNT_W-1:0] count_q;
	logic             dropped_q;
	logic [IDX_W-1:0] rd_addr_q;

	logic signed [VALUE_WIDTH-1:0] value_ext;
	logic        [VALUE_WIDTH-1:0] new_key;
	logic        [IDX_W-1:0]       new_idx;

	ctb_cell_stat_t   stat [MAX_LEN];
	logic [IDX_W-1:0] cell_node [MAX_LEN];
	logic [MAX_LEN-1:0] keep_vec, top_vec, pop_vec, push_vec;

	logic [IDX_W-1:0] popped_node, top_node;
	logic             has_pop, has_top;

	logic [IDX_W-1:0] idx_q, popped_q, top_q;
	logic             has_pop_q, has_top_q, last_q;

	logic [MAX_LEN-1:0] pa_v_q, pb_v_q, l_v_q, r_v_q;
	logic               link_we;

	logic [IDX_W-1:0] pa_rd, pb_rd, l_rd, r_rd;

	logic             rd_valid_s1, rd_last_s1, rd_ovf_s1;
	logic             pa_v_s1, pb_v_s1, l_v_s1, r_v_s1;
	logic [IDX_W-1:0] rd_node_s1;

	ctb_result_t result_s2;
	logic        strobe_s2;

	assign full      = count_q >= CNT_W'(MAX_LEN);
	assign accept    = start && !busy;
	assign value_ext = VALUE_WIDTH'(item.value);
	assign new_key   = value_ext ^ SIGN_MASK;
	assign new_idx   = count_q[IDX_W-1:0];
	assign issue_end = CNT_W'(rd_addr_q) == (count_q - CNT_W'(1));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!full) begin
						state_d = S_LINK;
					end else if (item.last_item) begin
						state_d = S_EMIT;
					end
				end
			end
			S_LINK: begin
				state_d = last_q ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (issue_end) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		busy    = 1'b1;
		insert  = 1'b0;
		link_we = 1'b0;
		issue   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy   = 1'b0;
				insert = accept && !full;
			end
			S_LINK: begin
				link_we = 1'b1;
			end
			S_EMIT: begin
				issue = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Row of stack cells.
	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		ctb_cell #(
			.KEY_W(VALUE_WIDTH),
			.IDX_W(IDX_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.insert    (insert),
			.clear     (issue && issue_end),
			.new_key   (new_key),
			.new_node  (new_idx),
			.below_keep((i == 0) ? 1'b1 : keep_vec[(i == 0) ? 0 : i - 1]),
			.above_keep((i == MAX_LEN - 1) ? 1'b0 : keep_vec[(i == MAX_LEN - 1) ? i : i + 1]),
			.stat      (stat[i]),
			.node      (cell_node[i])
		);
		assign keep_vec[i] = stat[i].keep;
		assign top_vec[i]  = stat[i].top;
		assign pop_vec[i]  = stat[i].first_pop;
		assign push_vec[i] = stat[i].push;
	end

	// The boundary flags are one-hot, so the selected node is an AND-OR.
	always_comb begin
		popped_node = '0;
		top_node    = '0;
		for (int i = 0; i < MAX_LEN; i++) begin
			popped_node = popped_node | (pop_vec[i] ? cell_node[i] : '0);
			top_node    = top_node | (top_vec[i] ? cell_node[i] : '0);
		end
	end
	assign has_pop = |pop_vec;
	assign has_top = |top_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			last_q    <= 1'b0;
			rd_addr_q <= '0;
		end else begin
			if (accept) begin
				last_q <= item.last_item;
			end
			if (issue && issue_end) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
				rd_addr_q <= '0;
			end else begin
				if (insert) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (accept && full) begin
					dropped_q <= 1'b1;
				end
				if (issue) begin
					rd_addr_q <= rd_addr_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (insert) begin
			idx_q     <= new_idx;
			popped_q  <= popped_node;
			top_q     <= top_node;
			has_pop_q <= has_pop;
			has_top_q <= has_top;
		end
	end

	// A node's parent is first set when it is pushed (pa) and replaced once
	// if it is later popped (pb), so the two live in separate memories.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_v_q <= '0;
			pb_v_q <= '0;
			l_v_q  <= '0;
			r_v_q  <= '0;
		end else if (issue && issue_end) begin
			pa_v_q <= '0;
			pb_v_q <= '0;
			l_v_q  <= '0;
			r_v_q  <= '0;
		end else if (link_we) begin
			if (has_top_q) begin
				pa_v_q[idx_q] <= 1'b1;
				r_v_q[top_q]  <= 1'b1;
			end
			if (has_pop_q) begin
				pb_v_q[popped_q] <= 1'b1;
				l_v_q[idx_q]     <= 1'b1;
			end
		end
	end

	ctb_link_ram #(.DEPTH(MAX_LEN), .DATA_W(IDX_W)) u_pa_ram (
		.clk  (clk),
		.we   (link_we && has_top_q),
		.waddr(idx_q),
		.wdata(top_q),
		.raddr(rd_addr_q),
		.rdata(pa_rd)
	);

	ctb_link_ram #(.DEPTH(MAX_LEN), .DATA_W(IDX_W)) u_pb_ram (
		.clk  (clk),
		.we   (link_we && has_pop_q),
		.waddr(popped_q),
		.wdata(idx_q),
		.raddr(rd_addr_q),
		.rdata(pb_rd)
	);

	ctb_link_ram #(.DEPTH(MAX_LEN), .DATA_W(IDX_W)) u_l_ram (
		.clk  (clk),
		.we   (link_we && has_pop_q),
		.waddr(idx_q),
		.wdata(popped_q),
		.raddr(rd_addr_q),
		.rdata(l_rd)
	);

	ctb_link_ram #(.DEPTH(MAX_LEN), .DATA_W(IDX_W)) u_r_ram (
		.clk  (clk),
		.we   (link_we && has_top_q),
		.waddr(top_q),
		.wdata(idx_q),
		.raddr(rd_addr_q),
		.rdata(r_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			strobe_s2   <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			strobe_s2   <= rd_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		rd_node_s1 <= rd_addr_q;
		rd_last_s1 <= issue_end;
		rd_ovf_s1  <= dropped_q;
		pa_v_s1    <= pa_v_q[rd_addr_q];
		pb_v_s1    <= pb_v_q[rd_addr_q];
		l_v_s1     <= l_v_q[rd_addr_q];
		r_v_s1     <= r_v_q[rd_addr_q];
	end

	always_ff @(posedge clk) begin
		result_s2.node_index   <= NODE_W'(rd_node_s1);
		result_s2.parent_index <= pb_v_s1 ? NODE_W'(pb_rd) : (pa_v_s1 ? NODE_W'(pa_rd) : '0);
		result_s2.parent_valid <= pb_v_s1 || pa_v_s1;
		result_s2.left_index   <= l_v_s1 ? NODE_W'(l_rd) : '0;
		result_s2.left_valid   <= l_v_s1;
		result_s2.right_index  <= r_v_s1 ? NODE_W'(r_rd) : '0;
		result_s2.right_valid  <= r_v_s1;
		result_s2.overflow     <= rd_ovf_s1;
		result_s2.last_node    <= rd_last_s1;
	end

	assign result       = result_s2;
	assign result_valid = strobe_s2;

	a_bound_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(top_vec) && $onehot0(pop_vec))
		else $error("stack boundary flags not one-hot");

	a_push_one: assert property (@(posedge clk) disable iff (!arst_n)
		insert |-> $onehot(push_vec))
		else $error("insert without exactly one push cell");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LEN))
		else $error("item count beyond capacity");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_node) |=> !result_valid)
		else $error("result beat right after the final node");

	a_insert_link: assert property (@(posedge clk) disable iff (!arst_n)
		insert |=> (state_q == S_LINK) && busy)
		else $error("insert not followed by link write");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
	import ctb_pkg::*;

	localparam int MAX_NODES = DEF_MAX_LEN;
	localparam logic [6:0] NO_LINK = 7'h7F;
	localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] VAL_MIN = 32'h8000_0000;

	// A one-element sequence yields a lone root with no links.
	localparam ctb_result_t LONE_ROOT = '{node_index: '0, parent_index: '0, parent_valid: 1'b0,
		left_index: '0, left_valid: 1'b0, right_index: '0, right_valid: 1'b0,
		overflow: 1'b0, last_node: 1'b1};

	typedef struct {
		logic [31:0] value;
		bit          last;
		bit          typed;
		ctb_result_t res;
	} stim_row_t;

	stim_row_t dir_rows [22] = '{
		'{VAL_MAX,       1'b1, 1'b1, LONE_ROOT},
		'{VAL_MIN,       1'b1, 1'b1, LONE_ROOT},
		'{32'd0,         1'b1, 1'b1, LONE_ROOT},
		'{32'hFFFF_FFFF, 1'b1, 1'b1, LONE_ROOT},
		'{32'd1,         1'b0, 1'b0, '0},
		'{32'd2,         1'b0, 1'b0, '0},
		'{32'd3,         1'b1, 1'b0, '0},
		'{32'd3,         1'b0, 1'b0, '0},
		'{32'd2,         1'b0, 1'b0, '0},
		'{32'd1,         1'b1, 1'b0, '0},
		'{32'd5,         1'b0, 1'b0, '0},
		'{32'd5,         1'b0, 1'b0, '0},
		'{32'd5,         1'b1, 1'b0, '0},
		'{VAL_MAX,       1'b0, 1'b0, '0},
		'{VAL_MIN,       1'b0, 1'b0, '0},
		'{VAL_MAX,       1'b0, 1'b0, '0},
		'{VAL_MIN,       1'b1, 1'b0, '0},
		'{32'd7,         1'b0, 1'b0, '0},
		'{32'd3,         1'b0, 1'b0, '0},
		'{32'd9,         1'b0, 1'b0, '0},
		'{32'd3,         1'b0, 1'b0, '0},
		'{32'hFFFF_FFFE, 1'b1, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	ctb_item_t   item;
	logic        result_valid;
	ctb_result_t result;

	cartesian_tree_builder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	// Shadow copy of the tree under construction.
	logic signed [31:0] key_stack [MAX_NODES];
	logic [5:0]         node_stack [MAX_NODES];
	logic [6:0]         parent_of [MAX_NODES];
	logic [6:0]         left_of [MAX_NODES];
	logic [6:0]         right_of [MAX_NODES];
	int                 depth;
	int                 node_count;
	bit                 dropped;

	ctb_result_t pending_nodes[$];
	int errors;
	int beats_checked;
	int inserted_items;
	int dropped_items;
	int sequences;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic forget_tree();
		depth = 0;
		node_count = 0;
		dropped = 1'b0;
		for (int i = 0; i < MAX_NODES; i++) begin
			parent_of[i] = NO_LINK;
			left_of[i] = NO_LINK;
			right_of[i] = NO_LINK;
		end
	endtask

	// Inserts one value into the shadow tree (or marks it dropped when full) and,
	// on the last item, returns the node beats of the whole sequence in index order.
	task automatic grow_tree(input ctb_item_t it, output ctb_result_t nodes[$]);
		logic [5:0]  idx;
		logic [6:0]  popped;
		ctb_result_t r;
		nodes = {};
		if (node_count >= MAX_NODES) begin
			dropped = 1'b1;
			dropped_items++;
		end else begin
			idx = node_count[5:0];
			popped = NO_LINK;
			while (depth > 0 && $signed(key_stack[depth-1]) > $signed(it.value)) begin
				popped = {1'b0, node_stack[depth-1]};
				depth--;
			end
			if (popped != NO_LINK) begin
				left_of[idx] = popped;
				parent_of[popped[5:0]] = {1'b0, idx};
			end
			if (depth > 0) begin
				parent_of[idx] = {1'b0, node_stack[depth-1]};
				right_of[node_stack[depth-1]] = {1'b0, idx};
			end
			node_stack[depth] = idx;
			key_stack[depth] = it.value;
			depth++;
			node_count++;
			inserted_items++;
		end
		if (it.last_item) begin
			for (int k = 0; k < node_count; k++) begin
				r.node_index   = k[5:0];
				r.parent_valid = parent_of[k] != NO_LINK;
				r.parent_index = r.parent_valid ? parent_of[k][5:0] : 6'd0;
				r.left_valid   = left_of[k] != NO_LINK;
				r.left_index   = r.left_valid ? left_of[k][5:0] : 6'd0;
				r.right_valid  = right_of[k] != NO_LINK;
				r.right_index  = r.right_valid ? right_of[k][5:0] : 6'd0;
				r.overflow     = dropped;
				r.last_node    = k == node_count - 1;
				nodes.push_back(r);
			end
			forget_tree();
			sequences++;
		end
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input ctb_item_t it, input int gap, input bit typed,
			input ctb_result_t typed_res);
		ctb_result_t nodes[$];
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		grow_tree(it, nodes);
		if (typed)
			pending_nodes.push_back(typed_res);
		else
			foreach (nodes[i]) pending_nodes.push_back(nodes[i]);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_nodes.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cmp_field(input string name, input int node, input int want, input int got);
		if (want != got) begin
			$display("%0t: node %0d %s expected %0d actual %0d", $time, node, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : node_monitor
		ctb_result_t want;
		if (arst_n && result_valid) begin
			if (pending_nodes.size() == 0) begin
				$display("%0t: unexpected beat, expected none actual %p", $time, result);
				errors++;
			end else begin
				want = pending_nodes.pop_front();
				beats_checked++;
				cmp_field("node_index", want.node_index, want.node_index, result.node_index);
				cmp_field("parent_index", want.node_index, want.parent_index,
					result.parent_index);
				cmp_field("parent_valid", want.node_index, want.parent_valid,
					result.parent_valid);
				cmp_field("left_index", want.node_index, want.left_index, result.left_index);
				cmp_field("left_valid", want.node_index, want.left_valid, result.left_valid);
				cmp_field("right_index", want.node_index, want.right_index,
					result.right_index);
				cmp_field("right_valid", want.node_index, want.right_valid,
					result.right_valid);
				cmp_field("overflow", want.node_index, want.overflow, result.overflow);
				cmp_field("last_node", want.node_index, want.last_node, result.last_node);
			end
		end
	end

	initial begin
		ctb_item_t   it;
		int          len;
		int          mode;
		int          gap_max;
		int          rand_items;
		logic [31:0] v;

		errors = 0;
		beats_checked = 0;
		inserted_items = 0;
		dropped_items = 0;
		sequences = 0;
		rand_items = 0;
		forget_tree();
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			it.value = dir_rows[i].value;
			it.last_item = dir_rows[i].last;
			send_item(it, $urandom_range(0, 3), dir_rows[i].typed, dir_rows[i].res);
		end

		// Two items past capacity, the second one carrying the end mark.
		for (int i = 0; i < MAX_NODES + 2; i++) begin
			it.value = $urandom;
			it.last_item = i == MAX_NODES + 1;
			send_item(it, $urandom_range(0, 2), 1'b0, '0);
		end
		drain();

		for (int s = 0; rand_items < 390; s++) begin
			case ($urandom_range(0, 19))
				0:       len = MAX_NODES;
				1:       len = $urandom_range(MAX_NODES + 1, MAX_NODES + 4);
				2, 3:    len = $urandom_range(20, 40);
				default: len = $urandom_range(1, 10);
			endcase
			mode = $urandom_range(0, 3);
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
			if (s % 6 == 5)
				drain();
			v = $urandom;
			for (int i = 0; i < len; i++) begin
				case (mode)
					0: v = $urandom;
					1: v = $urandom_range(0, 7) - 4;
					2: v = v + $urandom_range(0, 3);
					default: v = v - $urandom_range(0, 3);
				endcase
				if ($urandom_range(0, 15) == 0)
					v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
				it.value = v;
				it.last_item = i == len - 1;
				send_item(it, $urandom_range(0, gap_max), 1'b0, '0);
				rand_items++;
			end
		end

		drain();
		repeat (16) @(posedge clk);
		$display("Built %0d trees from %0d inserted values; %0d values fell past capacity.",
			sequences, inserted_items, dropped_items);
		$display("Checked %0d node beats, with %0d mismatches.", beats_checked, errors);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/ctb_pkg.sv
design/ctb_link_ram.sv
design/ctb_cell.sv
design/cartesian_tree_builder.sv
tb/sv/tb.sv
